FILE: hw/rtl/aligned_chunk_block_allocator_assert.svh
// Assertion macros shared by the chunk allocator RTL.
// Each macro places one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ALIGNED_CHUNK_BLOCK_ALLOCATOR_ASSERT_SVH
`define ALIGNED_CHUNK_BLOCK_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("acba assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ACBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("acba assertion failed");

`endif

FILE: hw/rtl/acba_pkg.sv
// Package for the aligned chunk block allocator: transaction payload types,
// status codes, memory control struct and controller state type. No dependencies.
`default_nettype none

package acba_pkg;

    typedef struct packed {
        logic        action;
        logic [31:0] alignment;
        logic [31:0] size;
        logic [31:0] address;
        logic        offered_valid;
        logic [11:0] offered_chunk;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] chunk_address;
        logic [31:0] released_address;
    } t_out_item;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [2:0] ST_ALLOC    = 3'd0;
    localparam logic [2:0] ST_REFUSED  = 3'd1;
    localparam logic [2:0] ST_NOBLOCK  = 3'd2;
    localparam logic [2:0] ST_FREED    = 3'd3;
    localparam logic [2:0] ST_NOTOWNED = 3'd4;
    localparam logic [2:0] ST_RELEASED = 3'd5;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctrl;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DEC,
        S_CHK,
        S_ADOPT,
        S_ALOC,
        S_FR_OWN,
        S_FR_DESC,
        S_WALK,
        S_WALK_RD,
        S_CLR,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/acba_owner_mem.sv
// Chunk owner map: one synchronous single-write, single-read memory with a
// clearing sweep after reset. Depends on acba_pkg for the control struct.
`default_nettype none

module acba_owner_mem #(
    parameter int DEPTH = 4096,
    parameter int DW    = 13,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  acba_pkg::t_mem_ctrl   i_ctrl,
    input  wire  [AW-1:0]         i_rd_addr,
    input  wire  [AW-1:0]         i_wr_addr,
    input  wire  [DW-1:0]         i_wr_data,
    output logic [DW-1:0]         o_rd_data,
    output logic                  o_busy
);
    import acba_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_clr_addr;
    logic          r_busy;
    logic [DW-1:0] r_rd_data;

    // After reset every entry is written to "no owner", one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

`default_nettype wire

FILE: hw/rtl/acba_desc_mem.sv
// Block descriptor store: next-block link and free-chunk mask per block start.
// Synchronous memory with registered read data; depends on acba_pkg.
`default_nettype none

module acba_desc_mem #(
    parameter int DEPTH = 4096,
    parameter int DW    = 21,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire                   i_clk,
    input  acba_pkg::t_mem_ctrl   i_ctrl,
    input  wire  [AW-1:0]         i_rd_addr,
    input  wire  [AW-1:0]         i_wr_addr,
    input  wire  [DW-1:0]         i_wr_data,
    output logic [DW-1:0]         o_rd_data
);
    import acba_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hw/rtl/aligned_chunk_block_allocator.sv
// Top level of the aligned chunk block allocator: controller, list head and
// output register. Depends on acba_pkg, acba_owner_mem, acba_desc_mem and the assert header.
`default_nettype none
`include "aligned_chunk_block_allocator_assert.svh"

// Each transaction is handled to completion before the next is taken, since
// the owner map and the descriptor store each have one read and one write
// port, and their read data is registered. An allocate served from the list
// reads and rewrites the head block's descriptor. Adopting an offered block
// first checks and then fills the owner entry of each of its chunks (the
// owner check and the owner fill each touch one chunk per cycle). A free reads
// the owner map, then reads and rewrites the block descriptor; a free that
// releases a block also walks the list to find its predecessor and then clears
// its owner entries. The result waits in S_OUT until the output register takes it.
// A finished result sits in an output register, so the next transaction is accepted while it waits.
// After reset the owner map is cleared one entry per cycle, and no input is
// accepted until that clearing sweep has ended.
module aligned_chunk_block_allocator #(
    parameter int CHUNK_SLOTS      = 4096,
    parameter int CHUNKS_PER_BLOCK = 8,
    parameter int CHUNK_SIZE_LOG2  = 20
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  acba_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output acba_pkg::t_out_item  o_out_data
);
    import acba_pkg::*;

    localparam int IW  = $clog2(CHUNK_SLOTS);
    localparam int OW  = $clog2(CHUNK_SLOTS + 1);
    localparam int LCW = $clog2(CHUNKS_PER_BLOCK);
    localparam int CPB = CHUNKS_PER_BLOCK;
    localparam int DW  = OW + CPB;
    localparam int XW  = 32 - CHUNK_SIZE_LOG2;
    localparam logic [CPB-1:0] FULL_MASK   = {CPB{1'b1}};
    localparam logic [31:0]    CHUNK_BYTES = 32'(1) << CHUNK_SIZE_LOG2;

    function automatic logic [31:0] chunk_to_addr(input logic [IW:0] chunk);
        logic [63:0] wide;
        wide = 64'(chunk) << CHUNK_SIZE_LOG2;
        return wide[31:0];
    endfunction

    t_state         r_state, n_state;
    t_in_item       r_item;
    logic [IW-1:0]  r_base, n_base;
    logic [IW-1:0]  r_idx, n_idx;
    logic [LCW-1:0] r_local, n_local;
    logic [LCW-1:0] r_cnt, n_cnt;
    logic [OW-1:0]  r_head, n_head;
    logic [OW-1:0]  r_cur, n_cur;
    logic [OW-1:0]  r_steps, n_steps;
    logic [OW-1:0]  r_link_blk, n_link_blk;
    t_out_item      r_res, n_res;
    logic           r_out_valid, n_out_valid;
    t_out_item      r_out;
    logic           in_accept;
    logic           out_load;

    t_mem_ctrl      own_ctrl;
    logic [IW-1:0]  own_rd_addr, own_wr_addr;
    logic [OW-1:0]  own_wr_data, own_rd_data;
    logic           own_busy;

    t_mem_ctrl      desc_ctrl;
    logic [IW-1:0]  desc_rd_addr, desc_wr_addr;
    logic [DW-1:0]  desc_wr_data, desc_rd_data;

    logic [OW-1:0]  desc_link;
    logic [CPB-1:0] desc_free;
    logic [LCW-1:0] low_idx;
    logic [CPB-1:0] alloc_left;
    logic [CPB-1:0] fr_after;
    logic [OW-1:0]  fr_blk;
    logic [OW-1:0]  fr_off;
    logic [IW:0]    clr_sum;
    logic [31:0]    offer_end;
    logic [XW-1:0]  addr_idx;
    logic           size_ok;
    logic           walk_go;

    acba_owner_mem #(
        .DEPTH (CHUNK_SLOTS),
        .DW    (OW)
    ) u_owner (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (own_ctrl),
        .i_rd_addr (own_rd_addr),
        .i_wr_addr (own_wr_addr),
        .i_wr_data (own_wr_data),
        .o_rd_data (own_rd_data),
        .o_busy    (own_busy)
    );

    acba_desc_mem #(
        .DEPTH (CHUNK_SLOTS),
        .DW    (DW)
    ) u_desc (
        .i_clk     (i_clk),
        .i_ctrl    (desc_ctrl),
        .i_rd_addr (desc_rd_addr),
        .i_wr_addr (desc_wr_addr),
        .i_wr_data (desc_wr_data),
        .o_rd_data (desc_rd_data)
    );

    assign desc_link  = desc_rd_data[DW-1:CPB];
    assign desc_free  = desc_rd_data[CPB-1:0];
    assign alloc_left = desc_free & ~(CPB'(1) << low_idx);
    assign fr_after   = desc_free | (CPB'(1) << r_local);
    assign fr_blk     = own_rd_data - OW'(1);
    assign fr_off     = OW'(r_idx) - fr_blk;
    assign clr_sum    = {1'b0, r_base} + (IW + 1)'(r_cnt);
    assign offer_end  = 32'(r_item.offered_chunk) + 32'(CPB);
    assign addr_idx   = r_item.address[31:CHUNK_SIZE_LOG2];
    assign size_ok    = (r_item.alignment == CHUNK_BYTES) && (r_item.size == CHUNK_BYTES);
    assign walk_go    = (r_cur != '0) && (r_cur <= OW'(CHUNK_SLOTS))
                        && (r_steps < OW'(CHUNK_SLOTS));

    // Lowest free chunk of the block whose descriptor was just read.
    always_comb begin
        low_idx = '0;
        for (int i = CPB - 1; i >= 0; i--) begin
            if (desc_free[i]) begin
                low_idx = LCW'(i);
            end
        end
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state      = r_state;
        n_base       = r_base;
        n_idx        = r_idx;
        n_local      = r_local;
        n_cnt        = r_cnt;
        n_head       = r_head;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_link_blk   = r_link_blk;
        n_res        = r_res;
        own_ctrl     = '0;
        own_rd_addr  = r_base;
        own_wr_addr  = r_base;
        own_wr_data  = '0;
        desc_ctrl    = '0;
        desc_rd_addr = r_base;
        desc_wr_addr = r_base;
        desc_wr_data = {desc_link, fr_after};

        unique case (r_state)
            S_INIT: begin
                if (!own_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_res = '{status: ST_NOBLOCK, chunk_address: '0, released_address: '0};
                if (r_item.action == ACT_ALLOC) begin
                    if (!size_ok) begin
                        n_res.status = ST_REFUSED;
                        n_state      = S_OUT;
                    end else if (r_head == '0) begin
                        if (!r_item.offered_valid || offer_end > 32'(CHUNK_SLOTS)) begin
                            n_state = S_OUT;
                        end else begin
                            // Check that every chunk of the offered block is unowned.
                            n_base         = IW'(r_item.offered_chunk);
                            n_cnt          = '0;
                            own_ctrl.rd_en = 1'b1;
                            own_rd_addr    = IW'(r_item.offered_chunk);
                            n_state        = S_CHK;
                        end
                    end else begin
                        n_base          = IW'(r_head - OW'(1));
                        desc_ctrl.rd_en = 1'b1;
                        desc_rd_addr    = IW'(r_head - OW'(1));
                        n_state         = S_ALOC;
                    end
                end else begin
                    if (32'(addr_idx) >= 32'(CHUNK_SLOTS)) begin
                        n_res.status = ST_NOTOWNED;
                        n_state      = S_OUT;
                    end else begin
                        n_idx          = IW'(addr_idx);
                        own_ctrl.rd_en = 1'b1;
                        own_rd_addr    = IW'(addr_idx);
                        n_state        = S_FR_OWN;
                    end
                end
            end
            S_CHK: begin
                if (own_rd_data != '0) begin
                    n_state = S_OUT;
                end else if (r_cnt == LCW'(CPB - 1)) begin
                    n_cnt   = '0;
                    n_state = S_ADOPT;
                end else begin
                    n_cnt          = r_cnt + LCW'(1);
                    own_ctrl.rd_en = 1'b1;
                    own_rd_addr    = r_base + IW'(r_cnt + LCW'(1));
                end
            end
            S_ADOPT: begin
                own_ctrl.wr_en = 1'b1;
                own_wr_addr    = r_base + IW'(r_cnt);
                own_wr_data    = OW'(r_base) + OW'(1);
                if (r_cnt == '0) begin
                    // The new block hands out chunk 0 right away.
                    desc_ctrl.wr_en = 1'b1;
                    desc_wr_addr    = r_base;
                    desc_wr_data    = {OW'(0), FULL_MASK & ~CPB'(1)};
                end
                if (r_cnt == LCW'(CPB - 1)) begin
                    n_head  = OW'(r_base) + OW'(1);
                    n_res   = '{status: ST_ALLOC,
                                chunk_address: chunk_to_addr({1'b0, r_base}),
                                released_address: '0};
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + LCW'(1);
                end
            end
            S_ALOC: begin
                if (desc_free == '0) begin
                    n_state = S_OUT;
                end else begin
                    desc_ctrl.wr_en = 1'b1;
                    desc_wr_addr    = r_base;
                    desc_wr_data    = {desc_link, alloc_left};
                    if (alloc_left == '0) begin
                        n_head = desc_link;
                    end
                    n_res   = '{status: ST_ALLOC,
                                chunk_address: chunk_to_addr({1'b0, r_base}
                                                             + (IW + 1)'(low_idx)),
                                released_address: '0};
                    n_state = S_OUT;
                end
            end
            S_FR_OWN: begin
                if (own_rd_data == '0 || fr_blk >= OW'(CHUNK_SLOTS)
                    || OW'(r_idx) < fr_blk || fr_off >= OW'(CPB)) begin
                    n_res.status = ST_NOTOWNED;
                    n_state      = S_OUT;
                end else begin
                    n_base          = IW'(fr_blk);
                    n_local         = LCW'(fr_off);
                    desc_ctrl.rd_en = 1'b1;
                    desc_rd_addr    = IW'(fr_blk);
                    n_state         = S_FR_DESC;
                end
            end
            S_FR_DESC: begin
                desc_ctrl.wr_en = 1'b1;
                desc_wr_addr    = r_base;
                n_res.status    = ST_FREED;
                if (desc_free == '0) begin
                    // A full block becomes partly free and goes onto the list.
                    desc_wr_data = {r_head, fr_after};
                    n_head       = OW'(r_base) + OW'(1);
                    n_state      = S_OUT;
                end else if (fr_after != FULL_MASK) begin
                    n_state = S_OUT;
                end else begin
                    n_link_blk = desc_link;
                    n_cnt      = '0;
                    if (r_head == OW'(r_base) + OW'(1)) begin
                        n_head  = desc_link;
                        n_state = S_CLR;
                    end else begin
                        n_cur   = r_head;
                        n_steps = '0;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (walk_go) begin
                    desc_ctrl.rd_en = 1'b1;
                    desc_rd_addr    = IW'(r_cur - OW'(1));
                    n_state         = S_WALK_RD;
                end else begin
                    n_state = S_CLR;
                end
            end
            S_WALK_RD: begin
                if (desc_link == OW'(r_base) + OW'(1)) begin
                    // Predecessor found: splice the released block out.
                    desc_ctrl.wr_en = 1'b1;
                    desc_wr_addr    = IW'(r_cur - OW'(1));
                    desc_wr_data    = {r_link_blk, desc_free};
                    n_state         = S_CLR;
                end else begin
                    n_cur   = desc_link;
                    n_steps = r_steps + OW'(1);
                    n_state = S_WALK;
                end
            end
            S_CLR: begin
                own_ctrl.wr_en = 1'b1;
                own_wr_addr    = IW'(clr_sum);
                own_wr_data    = '0;
                if (r_cnt == LCW'(CPB - 1) || clr_sum == (IW + 1)'(CHUNK_SLOTS - 1)) begin
                    n_res   = '{status: ST_RELEASED, chunk_address: '0,
                                released_address: chunk_to_addr({1'b0, r_base})};
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + LCW'(1);
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_data;
        end
        if (out_load) begin
            r_out <= r_res;
        end
        r_base     <= n_base;
        r_idx      <= n_idx;
        r_local    <= n_local;
        r_cnt      <= n_cnt;
        r_cur      <= n_cur;
        r_steps    <= n_steps;
        r_link_blk <= n_link_blk;
        r_res      <= n_res;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ACBA_ASSERT_NXT(a_accept_then_busy, i_clk, i_rst_n, in_accept, o_in_stall)
    `ACBA_ASSERT_IMP(a_owner_idle_while_clearing, i_clk, i_rst_n, own_busy, !own_ctrl.rd_en && !own_ctrl.wr_en)
    `ACBA_ASSERT_IMP(a_head_in_range, i_clk, i_rst_n, 1'b1, r_head <= OW'(CHUNK_SLOTS))
    `ACBA_ASSERT_IMP(a_status_in_range, i_clk, i_rst_n, r_out_valid, r_out.status <= ST_RELEASED)
    `ACBA_ASSERT_IMP(a_release_addr_only_on_release, i_clk, i_rst_n, r_out_valid && r_out.status != ST_RELEASED, r_out.released_address == '0)

endmodule

`default_nettype wire
